// File: design/lpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared constants, types and the control store of the layered profile
// interpolator.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int AW          = $clog2(MAX_ENTRIES);
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH_W     = 24;
  localparam int SPEED_W     = 24;
  localparam int ENTRY_W     = DEPTH_W + SPEED_W + 1;
  localparam int PROD_W      = 2 * SPEED_W;
  localparam int DIV_CNT_W   = $clog2(SPEED_W + 1);
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int PC_W        = 4;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_SPEED = 1'b1;

  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CLR   = 4'd1;
  localparam logic [PC_W-1:0] S_APP   = 4'd2;
  localparam logic [PC_W-1:0] S_QRY   = 4'd3;
  localparam logic [PC_W-1:0] S_FIRST = 4'd4;
  localparam logic [PC_W-1:0] S_LAST  = 4'd5;
  localparam logic [PC_W-1:0] S_SCAN  = 4'd6;
  localparam logic [PC_W-1:0] S_MUL   = 4'd7;
  localparam logic [PC_W-1:0] S_DIV   = 4'd8;
  localparam logic [PC_W-1:0] S_FIN   = 4'd9;
  localparam logic [PC_W-1:0] S_OUT   = 4'd10;
  localparam logic [PC_W-1:0] S_ERR   = 4'd11;

  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_CLEAR,
    A_APPEND,
    A_RD_FIRST,
    A_CHK_FIRST,
    A_CHK_LAST,
    A_SCAN,
    A_MUL,
    A_DIV,
    A_FIN,
    A_EMIT,
    A_ERR
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_EMPTY,
    C_LE_FIRST,
    C_GE_LAST,
    C_SCAN,
    C_CNT_LAST,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [PC_W-1:0]  tgt;
    logic             hold;
  } ucw_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      S_IDLE:  w = '{A_LATCH,     C_ACCEPT,   S_IDLE, 1'b1};
      S_CLR:   w = '{A_CLEAR,     C_ALWAYS,   S_OUT,  1'b0};
      S_APP:   w = '{A_APPEND,    C_ALWAYS,   S_OUT,  1'b0};
      S_QRY:   w = '{A_RD_FIRST,  C_EMPTY,    S_ERR,  1'b0};
      S_FIRST: w = '{A_CHK_FIRST, C_LE_FIRST, S_OUT,  1'b0};
      S_LAST:  w = '{A_CHK_LAST,  C_GE_LAST,  S_OUT,  1'b0};
      S_SCAN:  w = '{A_SCAN,      C_SCAN,     S_OUT,  1'b1};
      S_MUL:   w = '{A_MUL,       C_NEVER,    S_IDLE, 1'b0};
      S_DIV:   w = '{A_DIV,       C_CNT_LAST, S_FIN,  1'b1};
      S_FIN:   w = '{A_FIN,       C_NEVER,    S_IDLE, 1'b0};
      S_OUT:   w = '{A_EMIT,      C_OUT_FREE, S_IDLE, 1'b1};
      S_ERR:   w = '{A_ERR,       C_ALWAYS,   S_OUT,  1'b0};
      default: w = '{A_NONE,      C_ALWAYS,   S_IDLE, 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
    logic [PC_W-1:0] t;
    case (cmd)
      CMD_CLEAR:  t = S_CLR;
      CMD_APPEND: t = S_APP;
      CMD_QUERY:  t = S_QRY;
      default:    t = S_OUT;
    endcase
    return t;
  endfunction

endpackage

// File: design/layered_profile_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_profile_interpolator
// Layered depth/speed profile table with linear interpolation, run by a
// small microcoded sequencer.
// ----------------------------------------------------------------------------
// The slave stream carries commands: tuser holds the command, tdata the depth
// and speed, tlast marks an entry that ends its layer. Every beat accepted
// yields exactly one beat on the master stream: tdata holds the speed and
// tuser the status. The configuration port sets the top and bottom speeds.
// One command is processed at a time; s_axis_tready is high only while the
// sequencer waits in its idle step. Clear and append go from the idle step
// through their own step to the output step. A query reads the first entry,
// then the last, and stops there when the depth lies above or below the
// profile; otherwise it scans the entries linearly up to the end of the layer
// that holds the depth, then adds one multiply step, a 24-step restoring
// divider and one final add or subtract step when it interpolates. The scan
// reads one entry per cycle from the single-port table memory. The
// result sits in an output register; a stalled receiver holds the sequencer
// in its output step only when a second result is ready before the first
// one was taken. Reset empties the table, clears both speed registers and
// drops the output valid.
// ----------------------------------------------------------------------------
module layered_profile_interpolator
  import lpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,   // depth[23:0], speed[47:24]
  input  logic [CMD_W-1:0]      s_axis_tuser,   // command[1:0]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SPEED_W-1:0]    m_axis_tdata,   // speed_out[23:0]
  output logic [STAT_W-1:0]     m_axis_tuser,   // status[1:0]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SPEED_W-1:0]    cfg_data_i
);

  logic [PC_W-1:0]      pc_q, pc_d;
  logic [CW-1:0]        count_q;
  logic [SPEED_W-1:0]   top_q, bottom_q;
  logic                 out_valid_q;
  logic [SPEED_W-1:0]   out_data_q;
  logic [STAT_W-1:0]    out_stat_q;

  logic [CMD_W-1:0]     cmd_q;
  logic [DEPTH_W-1:0]   qd_q;
  logic [SPEED_W-1:0]   sp_in_q;
  logic                 ends_q;
  logic [SPEED_W-1:0]   res_q;
  logic [STAT_W-1:0]    st_q;

  logic [ENTRY_W-1:0]   mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0]   rdata_q;
  logic [AW-1:0]        rd_idx_q;

  logic                 found_q, at_start_q, jfirst_q;
  logic [DEPTH_W-1:0]   prev_dep_q, dl_q, dr_q, den_q;
  logic [SPEED_W-1:0]   prev_spd_q, sl_q, sr_q;
  logic [SPEED_W-1:0]   rem_q, quo_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  ucw_t                 uw;
  logic                 s_acc, out_free, full, cond_true;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        raddr, last_idx;
  logic [DEPTH_W-1:0]   e_dep;
  logic [SPEED_W-1:0]   e_spd;
  logic                 e_mark;
  logic                 is_end, deeper, hit, found_now, decide, jfirst_now, need_lerp;
  logic [DEPTH_W-1:0]   num;
  logic [SPEED_W-1:0]   diff;
  logic                 neg;
  logic [PROD_W-1:0]    prod;
  logic [SPEED_W:0]     trial;
  logic                 ge;

  assign uw            = ucode(pc_q);
  assign s_axis_tready = (uw.cond == C_ACCEPT);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (count_q == CW'(MAX_ENTRIES));
  assign last_idx      = AW'(count_q - CW'(1));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  assign e_dep  = rdata_q[DEPTH_W-1:0];
  assign e_spd  = rdata_q[DEPTH_W+SPEED_W-1:DEPTH_W];
  assign e_mark = rdata_q[ENTRY_W-1];

  assign is_end     = e_mark || (rd_idx_q == last_idx);
  assign deeper     = e_dep > qd_q;
  assign hit        = !found_q && deeper;
  assign found_now  = found_q || deeper;
  assign decide     = is_end && (e_dep >= qd_q);
  assign jfirst_now = hit ? at_start_q : jfirst_q;
  assign need_lerp  = decide && found_now && !jfirst_now;

  assign num   = qd_q - dl_q;
  assign neg   = sr_q < sl_q;
  assign diff  = neg ? (sl_q - sr_q) : (sr_q - sl_q);
  assign prod  = {{SPEED_W{1'b0}}, num} * {{DEPTH_W{1'b0}}, diff};
  assign trial = {rem_q, quo_q[SPEED_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    case (uw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_EMPTY:    cond_true = (count_q == '0);
      C_LE_FIRST: cond_true = (qd_q <= e_dep);
      C_GE_LAST:  cond_true = (qd_q >= e_dep);
      C_CNT_LAST: cond_true = (cnt_q == DIV_CNT_W'(1));
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      C_ACCEPT: pc_d = s_acc ? dispatch(s_axis_tuser) : pc_q;
      C_SCAN:   pc_d = !decide ? pc_q : (need_lerp ? pc_q + PC_W'(1) : uw.tgt);
      default:  pc_d = cond_true ? uw.tgt : (uw.hold ? pc_q : pc_q + PC_W'(1));
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    case (uw.act)
      A_RD_FIRST: begin
        rd_en = 1'b1;
      end
      A_CHK_FIRST: begin
        rd_en = 1'b1;
        raddr = last_idx;
      end
      A_CHK_LAST: begin
        rd_en = 1'b1;
      end
      A_SCAN: begin
        rd_en = 1'b1;
        raddr = rd_idx_q + AW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = (uw.act == A_APPEND) && !full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= {ends_q, sp_in_q, qd_q};
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      bottom_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TOP_SPEED) begin
          top_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_BOTTOM_SPEED) begin
          bottom_q <= cfg_data_i;
        end
      end
      if (uw.act == A_CLEAR) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
      if (uw.act == A_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= raddr;
    end
    case (uw.act)
      A_LATCH: begin
        if (s_acc) begin
          cmd_q   <= s_axis_tuser;
          qd_q    <= s_axis_tdata[DEPTH_W-1:0];
          sp_in_q <= s_axis_tdata[DEPTH_W+SPEED_W-1:DEPTH_W];
          ends_q  <= s_axis_tlast;
          res_q   <= '0;
          st_q    <= ST_OK;
        end
      end
      A_APPEND: begin
        if (full) begin
          st_q <= ST_FULL;
        end
      end
      A_CHK_FIRST: begin
        res_q <= (top_q != '0) ? top_q : e_spd;
      end
      A_CHK_LAST: begin
        res_q      <= (bottom_q != '0) ? bottom_q : e_spd;
        found_q    <= 1'b0;
        at_start_q <= 1'b1;
      end
      A_SCAN: begin
        prev_dep_q <= e_dep;
        prev_spd_q <= e_spd;
        if (hit) begin
          dr_q     <= e_dep;
          sr_q     <= e_spd;
          dl_q     <= prev_dep_q;
          sl_q     <= prev_spd_q;
          jfirst_q <= at_start_q;
        end
        found_q    <= is_end ? 1'b0 : found_now;
        at_start_q <= is_end;
        if (decide) begin
          res_q <= (hit || !found_now) ? e_spd : sr_q;
        end
      end
      A_MUL: begin
        rem_q <= prod[PROD_W-1:SPEED_W];
        quo_q <= prod[SPEED_W-1:0];
        den_q <= dr_q - dl_q;
        neg_q <= neg;
        cnt_q <= DIV_CNT_W'(SPEED_W);
      end
      A_DIV: begin
        rem_q <= ge ? SPEED_W'(trial - {1'b0, den_q}) : trial[SPEED_W-1:0];
        quo_q <= {quo_q[SPEED_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
      A_FIN: begin
        res_q <= neg_q ? (sl_q - quo_q) : (sl_q + quo_q);
      end
      A_EMIT: begin
        if (out_free) begin
          out_data_q <= (cmd_q == CMD_QUERY) ? res_q : '0;
          out_stat_q <= st_q;
        end
      end
      A_ERR: begin
        st_q <= ST_EMPTY;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds the table size");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q) == S_OUT)
    else $error("result loaded outside the output step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("error result carries a nonzero speed");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_DIV) |-> den_q != '0)
    else $error("interpolation divisor is zero");

endmodule
